FILE: sv/mcsp_pkg.sv
// ============================================================================
// Markov chain step power: shared package
// Sizes, command and register codes, state type and the MAC pipeline structs.
// ============================================================================
package mcsp_pkg;

    localparam int MAX_SIZE = 16;
    localparam int IDX_W    = $clog2(MAX_SIZE);
    localparam int ADDR_W   = 2 * IDX_W;
    localparam int DEPTH    = MAX_SIZE * MAX_SIZE;
    localparam int SIZE_W   = $clog2(MAX_SIZE + 1);

    localparam int PROB_W      = 32;
    localparam int PROD_W      = PROB_W + 1;
    localparam int SUM_W       = PROB_W + 2;
    localparam int STEP_W      = 16;
    localparam int FIELD_IDX_W = 4;
    localparam int MSIZE_W     = 5;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 56;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 5;

    localparam logic [PROB_W-1:0] Q_ONE   = 32'h8000_0000;
    localparam logic [STEP_W-1:0] STEP_MAX = 16'hFFFF;

    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_ADVANCE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_MATRIX_SIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WATCHED_ROW = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EMIT_RD,
        ST_EMIT_WR,
        ST_MAC,
        ST_DRAIN,
        ST_COPY,
        ST_COPY_END
    } t_state;

    typedef struct packed {
        logic             valid;
        logic             first;
        logic             last;
        logic [IDX_W-1:0] col;
    } t_mac_tag;

    typedef struct packed {
        logic              valid;
        logic [IDX_W-1:0]  col;
        logic [PROB_W-1:0] sum;
    } t_mac_res;

endpackage

FILE: sv/mcsp_mac.sv
// ============================================================================
// Markov chain step power: multiply and saturating accumulate
// Two-stage pipeline: a registered truncated Q1.31 product, then a running
// sum clamped at 1.0 that is handed out on the last term of each dot product.
// ============================================================================
module mcsp_mac
    import mcsp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_mac_tag          i_tag,
    input  logic [PROB_W-1:0] i_a,
    input  logic [PROB_W-1:0] i_b,
    output t_mac_res          o_res,
    output logic              o_busy
);

    logic [2*PROB_W-1:0] prod_full;
    t_mac_tag            r_tag;
    logic [PROD_W-1:0]   r_prod;
    logic [PROB_W-1:0]   r_acc;
    logic [PROB_W-1:0]   acc_base;
    logic [SUM_W-1:0]    sum_wide;
    logic [PROB_W-1:0]   sum_sat;

    assign prod_full = (2*PROB_W)'(i_a) * (2*PROB_W)'(i_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag <= '0;
        end else begin
            r_tag <= i_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= prod_full[2*PROB_W-1:PROB_W-1];
        if (r_tag.valid) begin
            r_acc <= sum_sat;
        end
    end

    always_comb begin
        acc_base = r_tag.first ? '0 : r_acc;
        sum_wide = {2'b00, acc_base} + {1'b0, r_prod};
        sum_sat  = (sum_wide > {2'b00, Q_ONE}) ? Q_ONE : sum_wide[PROB_W-1:0];
    end

    assign o_res.valid = r_tag.valid & r_tag.last;
    assign o_res.col   = r_tag.col;
    assign o_res.sum   = sum_sat;
    assign o_busy      = r_tag.valid;

endmodule

FILE: sv/markov_chain_step_power.sv
// ============================================================================
// Markov chain step power: top level
// Holds a transition matrix and its running power; each advance emits the
// watched row of the power and then multiplies the power by the matrix.
// ============================================================================
// A load transfer writes the entry into both the transition and the power
// memory. An advance emits n results (n being the effective matrix size,
// each zero when the watched row lies beyond n), and then updates the
// power matrix row by row through one shared multiply-accumulate unit fed from
// the two single-port-read memories: the reads for a row, a short pipeline
// drain and a copy of the row back. The input is not ready while an advance
// runs. The final result may still wait at the output while the update runs
// and while later loads are taken.
module markov_chain_step_power
    import mcsp_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // row_index [3:0], col_index [7:4], entry_value [39:8]
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // command [0]
    input  logic                   s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // step_number [15:0], column [19:16], probability [51:20], zero [55:52]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                   m_axis_tlast,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    logic [PROB_W-1:0] r_trans_mem [DEPTH];
    logic [PROB_W-1:0] r_pow_mem   [DEPTH];
    logic [PROB_W-1:0] r_scr_mem   [MAX_SIZE];
    logic [PROB_W-1:0] r_trans_q;
    logic [PROB_W-1:0] r_pow_q;
    logic [PROB_W-1:0] r_scr_q;

    t_state              r_state, n_state;
    logic [IDX_W-1:0]    r_i, n_i;
    logic [IDX_W-1:0]    r_j, n_j;
    logic [IDX_W-1:0]    r_k, n_k;
    logic [MSIZE_W-1:0]  r_size;
    logic [FIELD_IDX_W-1:0] r_watch;
    logic [STEP_W-1:0]   r_step;
    t_mac_tag            r_tag1;
    t_mac_tag            issue_tag;
    logic                r_cp_valid;
    logic [IDX_W-1:0]    r_cp_col;

    logic                r_out_valid;
    logic [STEP_W-1:0]   r_out_step;
    logic [IDX_W-1:0]    r_out_col;
    logic [PROB_W-1:0]   r_out_prob;
    logic                r_out_last;

    logic [SIZE_W-1:0]   eff_n;
    logic [IDX_W-1:0]    n_last;
    logic                watch_ok;
    logic                in_xfer;
    logic                load_wr;
    logic [FIELD_IDX_W-1:0] in_row;
    logic [FIELD_IDX_W-1:0] in_col;
    logic [PROB_W-1:0]   in_value;
    logic [ADDR_W-1:0]   load_addr;
    logic [ADDR_W-1:0]   pow_raddr;
    logic [ADDR_W-1:0]   trans_raddr;
    logic                out_load;
    logic                step_inc;
    logic                cp_issue;
    t_mac_res            mac_res;
    logic                mac_busy;

    assign in_row   = s_axis_tdata[3:0];
    assign in_col   = s_axis_tdata[7:4];
    assign in_value = s_axis_tdata[39:8];

    assign s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign in_xfer       = s_axis_tvalid & s_axis_tready;
    assign load_wr       = in_xfer && (s_axis_tuser == CMD_LOAD)
                           && (32'(in_row) < 32'(MAX_SIZE))
                           && (32'(in_col) < 32'(MAX_SIZE));
    assign load_addr     = {IDX_W'(in_row), IDX_W'(in_col)};

    always_comb begin
        if (r_size == '0) begin
            eff_n = SIZE_W'(1);
        end else if (32'(r_size) > 32'(MAX_SIZE)) begin
            eff_n = SIZE_W'(MAX_SIZE);
        end else begin
            eff_n = SIZE_W'(r_size);
        end
    end

    assign n_last   = IDX_W'(eff_n - SIZE_W'(1));
    assign watch_ok = (32'(r_watch) < 32'(eff_n));

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size  <= MSIZE_W'(2);
            r_watch <= FIELD_IDX_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_MATRIX_SIZE: r_size  <= MSIZE_W'(i_cfg_data);
                CFG_WATCHED_ROW: r_watch <= i_cfg_data[FIELD_IDX_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer.
    always_comb begin
        n_state     = r_state;
        n_i         = r_i;
        n_j         = r_j;
        n_k         = r_k;
        pow_raddr   = {r_i, r_k};
        trans_raddr = {r_k, r_j};
        issue_tag   = '0;
        out_load    = 1'b0;
        step_inc    = 1'b0;
        cp_issue    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (in_xfer && (s_axis_tuser == CMD_ADVANCE)) begin
                    n_j     = '0;
                    n_state = ST_EMIT_RD;
                end
            end
            ST_EMIT_RD: begin
                pow_raddr = {IDX_W'(r_watch), r_j};
                if (!r_out_valid) begin
                    n_state = ST_EMIT_WR;
                end
            end
            ST_EMIT_WR: begin
                out_load = 1'b1;
                if (r_j == n_last) begin
                    n_i     = '0;
                    n_j     = '0;
                    n_k     = '0;
                    n_state = ST_MAC;
                end else begin
                    n_j     = r_j + IDX_W'(1);
                    n_state = ST_EMIT_RD;
                end
            end
            ST_MAC: begin
                issue_tag.valid = 1'b1;
                issue_tag.first = (r_k == '0);
                issue_tag.last  = (r_k == n_last);
                issue_tag.col   = r_j;
                if (r_k == n_last) begin
                    n_k = '0;
                    if (r_j == n_last) begin
                        n_j     = '0;
                        n_state = ST_DRAIN;
                    end else begin
                        n_j = r_j + IDX_W'(1);
                    end
                end else begin
                    n_k = r_k + IDX_W'(1);
                end
            end
            ST_DRAIN: begin
                if (!r_tag1.valid && !mac_busy) begin
                    n_state = ST_COPY;
                end
            end
            ST_COPY: begin
                cp_issue = 1'b1;
                if (r_j == n_last) begin
                    n_j     = '0;
                    n_state = ST_COPY_END;
                end else begin
                    n_j = r_j + IDX_W'(1);
                end
            end
            ST_COPY_END: begin
                if (r_i == n_last) begin
                    step_inc = 1'b1;
                    n_state  = ST_IDLE;
                end else begin
                    n_i     = r_i + IDX_W'(1);
                    n_state = ST_MAC;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_i        <= '0;
            r_j        <= '0;
            r_k        <= '0;
            r_step     <= STEP_W'(1);
            r_tag1     <= '0;
            r_cp_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_i        <= n_i;
            r_j        <= n_j;
            r_k        <= n_k;
            r_tag1     <= issue_tag;
            r_cp_valid <= cp_issue;
            if (step_inc && (r_step != STEP_MAX)) begin
                r_step <= r_step + STEP_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cp_col <= r_j;
    end

    // Transition memory.
    always_ff @(posedge i_clk) begin
        if (load_wr) begin
            r_trans_mem[load_addr] <= in_value;
        end
        r_trans_q <= r_trans_mem[trans_raddr];
    end

    // Power memory: written by loads and by the row copy, never both at once.
    always_ff @(posedge i_clk) begin
        if (load_wr) begin
            r_pow_mem[load_addr] <= in_value;
        end else if (r_cp_valid) begin
            r_pow_mem[{r_i, r_cp_col}] <= r_scr_q;
        end
        r_pow_q <= r_pow_mem[pow_raddr];
    end

    // Row scratch memory.
    always_ff @(posedge i_clk) begin
        if (mac_res.valid) begin
            r_scr_mem[mac_res.col] <= mac_res.sum;
        end
        r_scr_q <= r_scr_mem[r_j];
    end

    mcsp_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (r_tag1),
        .i_a     (r_pow_q),
        .i_b     (r_trans_q),
        .o_res   (mac_res),
        .o_busy  (mac_busy)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_step <= r_step;
            r_out_col  <= r_j;
            r_out_prob <= watch_ok ? r_pow_q : '0;
            r_out_last <= (r_j == n_last);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = {4'b0000, r_out_prob, FIELD_IDX_W'(r_out_col), r_out_step};

endmodule

FILE: verif/markov_chain_step_power_tb.sv
// ============================================================================
// Markov chain step power: testbench
// Loads transition entries and issues advance commands over the stream input,
// predicts every emitted row entry with its own copy of the transition and
// power matrices, and compares each output transfer field by field. Covers the
// register extremes, out-of-size loads, watched rows beyond the size, output
// back-pressure and random traffic.
// ============================================================================
module markov_chain_step_power_tb;
    import mcsp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [STEP_W-1:0]      step;
        logic [FIELD_IDX_W-1:0] col;
        logic [PROB_W-1:0]      prob;
        logic                   last;
    } t_row_entry;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   s_axis_tuser = CMD_LOAD;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tlast;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = CFG_MATRIX_SIZE;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    // Predicted state of the block.
    logic [PROB_W-1:0]  trans_m [MAX_SIZE][MAX_SIZE];
    logic [PROB_W-1:0]  pow_m [MAX_SIZE][MAX_SIZE];
    logic [STEP_W-1:0]  step_cnt = 16'd1;
    logic [MSIZE_W-1:0] mdl_size = 5'd2;
    logic [IDX_W-1:0]   mdl_row = 4'd1;
    t_row_entry         due_entries [$];

    // Stimulus bookkeeping.
    bit                 loaded [MAX_SIZE][MAX_SIZE];
    logic [MSIZE_W-1:0] drv_size = 5'd2;
    int                 err_cnt = 0;
    bit                 idle_on = 1'b1;
    int                 hold_req = 0;
    int                 stall_left = 0;

    markov_chain_step_power uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic int eff_size(input logic [MSIZE_W-1:0] s);
        if (s == 0) return 1;
        if (s > MAX_SIZE) return MAX_SIZE;
        return int'(s);
    endfunction

    function automatic void mul_power(input int n);
        logic [63:0]       acc;
        logic [63:0]       prod;
        logic [PROB_W-1:0] row_new [MAX_SIZE];
        for (int i = 0; i < n; i++) begin
            for (int j = 0; j < n; j++) begin
                acc = '0;
                for (int k = 0; k < n; k++) begin
                    prod = ({32'd0, pow_m[i][k]} * {32'd0, trans_m[k][j]}) >> 31;
                    acc  = acc + prod;
                    if (acc > {32'd0, Q_ONE}) acc = {32'd0, Q_ONE};
                end
                row_new[j] = acc[PROB_W-1:0];
            end
            for (int j = 0; j < n; j++) pow_m[i][j] = row_new[j];
        end
    endfunction

    task automatic predict_item(input logic cmd, input logic [IN_TDATA_W-1:0] d);
        logic [IDX_W-1:0] r;
        logic [IDX_W-1:0] c;
        t_row_entry       e;
        int               n;
        r = d[3:0];
        c = d[7:4];
        if (cmd == CMD_LOAD) begin
            trans_m[r][c] = d[39:8];
            pow_m[r][c]   = d[39:8];
        end else begin
            n = eff_size(mdl_size);
            for (int j = 0; j < n; j++) begin
                e.step = step_cnt;
                e.col  = 4'(j);
                e.prob = (int'(mdl_row) < n) ? pow_m[mdl_row][j] : '0;
                e.last = (j == n - 1);
                due_entries.push_back(e);
            end
            mul_power(n);
            if (step_cnt != STEP_MAX) step_cnt = step_cnt + 16'd1;
        end
    endtask

    task automatic check_result;
        t_row_entry want;
        if (due_entries.size() == 0) begin
            $display("%0t: unexpected result, data %h last %b", $time, m_axis_tdata,
                     m_axis_tlast);
            err_cnt++;
        end else begin
            want = due_entries.pop_front();
            if (m_axis_tdata[15:0] !== want.step) begin
                $display("%0t: step mismatch, expected %0d, actual %0d", $time, want.step,
                         m_axis_tdata[15:0]);
                err_cnt++;
            end
            if (m_axis_tdata[19:16] !== want.col) begin
                $display("%0t: column mismatch, expected %0d, actual %0d", $time, want.col,
                         m_axis_tdata[19:16]);
                err_cnt++;
            end
            if (m_axis_tdata[51:20] !== want.prob) begin
                $display("%0t: probability mismatch, expected %h, actual %h", $time,
                         want.prob, m_axis_tdata[51:20]);
                err_cnt++;
            end
            if (m_axis_tlast !== want.last) begin
                $display("%0t: last mismatch, expected %b, actual %b", $time, want.last,
                         m_axis_tlast);
                err_cnt++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) check_result();
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_MATRIX_SIZE) mdl_size = i_cfg_data;
                else mdl_row = i_cfg_data[IDX_W-1:0];
            end
            if (s_axis_tvalid && s_axis_tready) predict_item(s_axis_tuser, s_axis_tdata);
        end
    end

    always @(posedge i_clk) begin
        if (hold_req > 0) begin
            stall_left = hold_req;
            hold_req   = 0;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= !(idle_on && $urandom_range(99) < 19);
        end
    end

    // The valid stays high after a transfer so that back-to-back items need no
    // second assignment in the same step; wait_quiet lowers it.
    task automatic send_item(input logic cmd, input logic [IDX_W-1:0] r,
                             input logic [IDX_W-1:0] c, input logic [PROB_W-1:0] v);
        if (idle_on && $urandom_range(99) < 19) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < 19);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {v, c, r};
        if (cmd == CMD_LOAD) loaded[r][c] = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic send_advance;
        send_item(CMD_ADVANCE, 4'($urandom_range(15)), 4'($urandom_range(15)), $urandom);
    endtask

    task automatic wait_quiet;
        int n;
        n = eff_size(drv_size);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (due_entries.size() != 0) @(posedge i_clk);
        repeat (2 * (n * n * n + n * n + 7 * n) + 32) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] sz,
                             input logic [CFG_DATA_W-1:0] wr);
        wait_quiet();
        write_reg(CFG_MATRIX_SIZE, sz);
        write_reg(CFG_WATCHED_ROW, wr);
        i_cfg_valid <= 1'b0;
        drv_size = sz;
    endtask

    task automatic ensure_loaded(input int n);
        for (int r = 0; r < n; r++) begin
            for (int c = 0; c < n; c++) begin
                if (!loaded[r][c]) send_item(CMD_LOAD, 4'(r), 4'(c), $urandom_range(Q_ONE / n));
            end
        end
    endtask

    function automatic logic [PROB_W-1:0] pick_prob(input int n);
        case ($urandom_range(9))
            0:       return '0;
            1:       return Q_ONE;
            2:       return 32'hFFFF_FFFF;
            3, 4:    return $urandom;
            default: return $urandom_range(Q_ONE / n);
        endcase
    endfunction

    task automatic test_default_config;
        send_item(CMD_LOAD, 4'd0, 4'd0, 32'h4000_0000);
        send_item(CMD_LOAD, 4'd0, 4'd1, 32'h4000_0000);
        send_item(CMD_LOAD, 4'd1, 4'd0, 32'h2000_0000);
        send_item(CMD_LOAD, 4'd1, 4'd1, 32'h6000_0000);
        send_advance();
        send_advance();
    endtask

    task automatic test_value_extremes;
        configure(5'd3, 5'd0);
        send_item(CMD_LOAD, 4'd0, 4'd0, 32'h0000_0000);
        send_item(CMD_LOAD, 4'd0, 4'd1, Q_ONE);
        send_item(CMD_LOAD, 4'd0, 4'd2, 32'hFFFF_FFFF);
        send_item(CMD_LOAD, 4'd1, 4'd0, 32'h7FFF_FFFF);
        send_item(CMD_LOAD, 4'd1, 4'd1, 32'h0000_0001);
        send_item(CMD_LOAD, 4'd1, 4'd2, Q_ONE);
        send_item(CMD_LOAD, 4'd2, 4'd0, 32'hFFFF_FFFF);
        send_item(CMD_LOAD, 4'd2, 4'd1, 32'hFFFF_FFFF);
        send_item(CMD_LOAD, 4'd2, 4'd2, 32'h0000_0000);
        send_advance();
        send_advance();
    endtask

    task automatic test_watched_row_beyond;
        configure(5'd3, 5'd5);
        send_advance();
        configure(5'd3, 5'h1F);
        send_advance();
        configure(5'd0, 5'd1);
        send_advance();
    endtask

    task automatic test_size_limits;
        configure(5'd0, 5'd0);
        send_item(CMD_LOAD, 4'd15, 4'd15, 32'hFFFF_FFFF);
        send_item(CMD_LOAD, 4'd15, 4'd0, 32'h0000_0001);
        send_item(CMD_LOAD, 4'd0, 4'd15, Q_ONE);
        send_advance();
        configure(5'd31, 5'd15);
        ensure_loaded(MAX_SIZE);
        send_advance();
        send_advance();
        configure(5'd16, 5'd0);
        send_advance();
    endtask

    task automatic test_backpressure;
        configure(5'd4, 5'd2);
        ensure_loaded(4);
        idle_on  = 1'b0;
        hold_req = 400;
        repeat (4) begin
            send_advance();
            send_item(CMD_LOAD, 4'($urandom_range(3)), 4'($urandom_range(3)), pick_prob(4));
        end
        send_advance();
        wait_quiet();
        idle_on = 1'b1;
    endtask

    task automatic test_random;
        int               sent;
        int               n;
        int               len;
        int               pick;
        logic [MSIZE_W-1:0] sz;
        logic [MSIZE_W-1:0] wr;
        sent = 0;
        while (sent < 140) begin
            idle_on = ($urandom_range(5) != 0);
            pick    = $urandom_range(19);
            if (pick == 0) sz = 5'(16 + $urandom_range(15));
            else if (pick == 1) sz = 5'd0;
            else sz = 5'($urandom_range(1, 6));
            n  = eff_size(sz);
            wr = ($urandom_range(3) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(n - 1));
            configure(sz, wr);
            ensure_loaded(n);
            len = (n > 8) ? 3 : $urandom_range(8, 20);
            repeat (len) begin
                if ($urandom_range(2) == 0) begin
                    send_advance();
                end else if ($urandom_range(4) == 0) begin
                    send_item(CMD_LOAD, 4'($urandom_range(15)), 4'($urandom_range(15)),
                              pick_prob(n));
                end else begin
                    send_item(CMD_LOAD, 4'($urandom_range(n - 1)), 4'($urandom_range(n - 1)),
                              pick_prob(n));
                end
                sent++;
            end
        end
        wait_quiet();
        idle_on = 1'b1;
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_default_config();
        test_value_extremes();
        test_watched_row_beyond();
        test_size_limits();
        test_backpressure();
        test_random();
        wait_quiet();
        if (err_cnt == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #400_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: filelist.f
sv/mcsp_pkg.sv
sv/mcsp_mac.sv
sv/markov_chain_step_power.sv
verif/markov_chain_step_power_tb.sv
